// ===== rtl/lcd4_pkg.sv =====
// Shared types, register indexes and init sequence table for the LCD command sequencer.
package lcd4_pkg;

  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_POS   = 2'd2;
  localparam logic [1:0] KIND_INIT  = 2'd3;

  localparam logic [2:0] CFG_NIBBLE_WAIT = 3'd0;
  localparam logic [2:0] CFG_ROW0        = 3'd1;
  localparam logic [2:0] CFG_ROW1        = 3'd2;
  localparam logic [2:0] CFG_ROW2        = 3'd3;
  localparam logic [2:0] CFG_ROW3        = 3'd4;

  localparam logic [7:0] NIBBLE_WAIT_RST = 8'd3;
  localparam logic [6:0] ROW0_RST        = 7'h00;
  localparam logic [6:0] ROW1_RST        = 7'h40;
  localparam logic [6:0] ROW2_RST        = 7'h14;
  localparam logic [6:0] ROW3_RST        = 7'h54;

  localparam logic [7:0] SET_ADDR_CMD = 8'h80;

  localparam logic [7:0] INIT_FUNC_SET  = 8'h28;
  localparam logic [7:0] INIT_DISP_OFF  = 8'h08;
  localparam logic [7:0] INIT_CLEAR     = 8'h01;
  localparam logic [7:0] INIT_ENTRY     = 8'h06;
  localparam logic [7:0] INIT_DISP_ON   = 8'h0C;
  localparam logic [3:0] INIT_WAKE_NIB  = 4'h3;
  localparam logic [3:0] INIT_4BIT_NIB  = 4'h2;
  localparam logic [6:0] INIT_WAIT_0    = 7'd16;
  localparam logic [6:0] INIT_WAIT_1    = 7'd5;
  localparam logic [6:0] INIT_WAIT_2    = 7'd100;

  localparam logic [3:0] LAST_BYTE_STEP = 4'd1;
  localparam logic [3:0] LAST_INIT_STEP = 4'd13;

  typedef struct packed {
    logic       rs;
    logic [7:0] byte_val;
    logic       init;
  } entry_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [6:0] extra;
  } strobe_t;

  function automatic strobe_t init_strobe(input logic [3:0] step);
    strobe_t s;
    s.extra = 7'd0;
    unique case (step)
      4'd0:    begin s.nibble = INIT_WAKE_NIB; s.extra = INIT_WAIT_0; end
      4'd1:    begin s.nibble = INIT_WAKE_NIB; s.extra = INIT_WAIT_1; end
      4'd2:    begin s.nibble = INIT_WAKE_NIB; s.extra = INIT_WAIT_2; end
      4'd3:    s.nibble = INIT_4BIT_NIB;
      4'd4:    s.nibble = INIT_FUNC_SET[7:4];
      4'd5:    s.nibble = INIT_FUNC_SET[3:0];
      4'd6:    s.nibble = INIT_DISP_OFF[7:4];
      4'd7:    s.nibble = INIT_DISP_OFF[3:0];
      4'd8:    s.nibble = INIT_CLEAR[7:4];
      4'd9:    s.nibble = INIT_CLEAR[3:0];
      4'd10:   s.nibble = INIT_ENTRY[7:4];
      4'd11:   s.nibble = INIT_ENTRY[3:0];
      4'd12:   s.nibble = INIT_DISP_ON[7:4];
      4'd13:   s.nibble = INIT_DISP_ON[3:0];
      default: s.nibble = 4'h0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/char_lcd_4bit_command_sequencer.sv =====
// Top level of the 4-bit character LCD command sequencer.
//
// Input channel (in_valid/in_stall): one command per transfer with kind, value,
// column and row. Instruction, character and set-position commands each give
// two nibble strobes; initialize gives fourteen.
// Output channel (out_valid/out_stall): one transfer per E strobe, carrying
// reg_select, data_nibble, wait_ms and last (set on a command's final strobe).
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high; write
// cfg_data to register cfg_index (0 nibble wait, 1..4 row starts) while idle.
// Path: a command is written into a queue slot, and its first strobe is then
// registered in the output register, from which it can transfer.
// Throughput: one strobe per cycle from the sequencer while out_stall is low and
// the queue holds a command; the sequencer's step counter walks each command's
// strobes. The input is taken while the queue of QUEUE_DEPTH entries has room.
// Reset empties the queue, clears out_valid and the step counter and loads the register defaults.
// While the receiver stalls, the held strobe stays put and the queue fills,
// then in_stall rises.
module char_lcd_4bit_command_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  input  logic [7:0] column,
  input  logic [1:0] row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       reg_select,
  output logic [3:0] data_nibble,
  output logic [8:0] wait_ms,
  output logic       last
);

  lcd4_pkg::entry_t new_entry;
  lcd4_pkg::entry_t head;
  logic [7:0]       nibble_wait;
  logic             full;
  logic             head_valid;
  logic             pop;
  logic             push;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign push      = in_valid && !full;

  lcd4_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (kind),
    .value       (value),
    .column      (column),
    .row         (row),
    .entry       (new_entry),
    .nibble_wait (nibble_wait)
  );

  lcd4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (new_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (head_valid),
    .head       (head)
  );

  lcd4_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .nibble_wait (nibble_wait),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reg_select  (reg_select),
    .data_nibble (data_nibble),
    .wait_ms     (wait_ms),
    .last        (last)
  );

endmodule

// ===== rtl/lcd4_front.sv =====
// Front end: configuration registers and command classification into queue entries.
module lcd4_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [1:0]          kind,
  input  logic [7:0]          value,
  input  logic [7:0]          column,
  input  logic [1:0]          row,
  output lcd4_pkg::entry_t    entry,
  output logic [7:0]          nibble_wait
);

  logic [6:0] row_start [4];
  logic [7:0] pos_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_wait  <= lcd4_pkg::NIBBLE_WAIT_RST;
      row_start[0] <= lcd4_pkg::ROW0_RST;
      row_start[1] <= lcd4_pkg::ROW1_RST;
      row_start[2] <= lcd4_pkg::ROW2_RST;
      row_start[3] <= lcd4_pkg::ROW3_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lcd4_pkg::CFG_NIBBLE_WAIT: nibble_wait  <= cfg_data;
        lcd4_pkg::CFG_ROW0:        row_start[0] <= cfg_data[6:0];
        lcd4_pkg::CFG_ROW1:        row_start[1] <= cfg_data[6:0];
        lcd4_pkg::CFG_ROW2:        row_start[2] <= cfg_data[6:0];
        lcd4_pkg::CFG_ROW3:        row_start[3] <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign pos_addr = lcd4_pkg::SET_ADDR_CMD + {1'b0, row_start[row]} + column;

  always_comb begin
    entry.init = 1'b0;
    unique case (kind)
      lcd4_pkg::KIND_INSTR: begin entry.rs = 1'b0; entry.byte_val = value;    end
      lcd4_pkg::KIND_CHAR:  begin entry.rs = 1'b1; entry.byte_val = value;    end
      lcd4_pkg::KIND_POS:   begin entry.rs = 1'b0; entry.byte_val = pos_addr; end
      default: begin
        entry.rs       = 1'b0;
        entry.byte_val = 8'h00;
        entry.init     = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/lcd4_queue.sv =====
// Short command queue between the front end and the strobe sequencer.
module lcd4_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lcd4_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output lcd4_pkg::entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcd4_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop) else $error("pop from empty queue");

endmodule

// ===== rtl/lcd4_back.sv =====
// Back end: steps through the nibble strobes of the head entry into the output register.
module lcd4_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  lcd4_pkg::entry_t head,
  input  logic [7:0]       nibble_wait,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             reg_select,
  output logic [3:0]       data_nibble,
  output logic [8:0]       wait_ms,
  output logic             last
);

  logic              [3:0] step;
  logic              [3:0] step_next;
  logic                    load;
  logic                    is_last;
  lcd4_pkg::strobe_t       init_s;
  logic              [3:0] nib;
  logic              [6:0] extra;

  assign load   = head_valid && (!out_valid || !out_stall);
  assign init_s = lcd4_pkg::init_strobe(step);

  always_comb begin
    if (head.init) begin
      nib     = init_s.nibble;
      extra   = init_s.extra;
      is_last = (step == lcd4_pkg::LAST_INIT_STEP);
    end else begin
      nib     = step[0] ? head.byte_val[3:0] : head.byte_val[7:4];
      extra   = 7'd0;
      is_last = (step == lcd4_pkg::LAST_BYTE_STEP);
    end
  end

  assign pop       = load && is_last;
  assign step_next = pop ? 4'd0 : step + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step <= step_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reg_select  <= head.rs;
      data_nibble <= nib;
      wait_ms     <= {1'b0, nibble_wait} + {2'b00, extra};
      last        <= is_last;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= lcd4_pkg::LAST_INIT_STEP) else $error("step out of range");
  a_byte_steps: assert property (@(posedge clk) disable iff (rst)
    head_valid && !head.init |-> step <= lcd4_pkg::LAST_BYTE_STEP)
    else $error("byte command past second nibble");
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && last) else $error("entry dropped without last strobe");

endmodule
